// ===== rtl/rau_pkg.sv =====
package rau_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAG_W = 32;
	localparam int PROD_W = 64;

	localparam logic [3:0] OP_RED = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_MUL = 4'd3;
	localparam logic [3:0] OP_DIV = 4'd4;
	localparam logic [3:0] OP_CMP = 4'd5;
	localparam logic [3:0] OP_NEG = 4'd6;
	localparam logic [3:0] OP_INV = 4'd7;
	localparam logic [3:0] OP_POW = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic [1:0] CMP_LT = 2'd0;
	localparam logic [1:0] CMP_EQ = 2'd1;
	localparam logic [1:0] CMP_GT = 2'd2;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit.
// Input channel: in_valid/in_stall with op, a_num/a_den, b_num/b_den and exponent.
// Output channel: out_valid/out_stall with res_num/res_den, cmp_result and status.
// Every item gives exactly one result, reduced by the gcd with a positive denominator.
// The block takes one item at a time; in_stall is high from acceptance until the
// result has been written to the output register.
// A single 32x32 multiplier forms all products, one per cycle; power multiplies
// the running numerator and then the denominator once per exponent step, at most 64 steps.
// Reduction runs a binary gcd, one subtract or shift per cycle, then two restoring
// divisions by the gcd, first of the numerator and then of the denominator.
// When the receiver stalls, the finished result waits in the output register and the
// next item may still be accepted; its own result is held back until the register frees.
// Reset clears the sequencer, the output valid and the divider control; datapath registers are not reset.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	input  logic [31:0] exponent,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0]  cmp_result,
	output logic [1:0]  status
);

	localparam logic [PROD_W-1:0] LIM = (PROD_W'(1) << (VALUE_WIDTH - 1)) - PROD_W'(1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_RED  = 4'd3;
	localparam logic [3:0] S_GCD  = 4'd4;
	localparam logic [3:0] S_DIVN = 4'd5;
	localparam logic [3:0] S_DIVD = 4'd6;
	localparam logic [3:0] S_PSET = 4'd7;
	localparam logic [3:0] S_PN   = 4'd8;
	localparam logic [3:0] S_PD   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
		return v[MAG_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [3:0]        state_q;
	logic [3:0]        op_q;
	logic [MAG_W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic              aneg_q, bneg_q;
	logic [31:0]       k_q;
	logic [PROD_W-1:0] x_q, y_q;
	logic              neg_q;
	logic [1:0]        stat_q, cmp_q;
	logic [1:0]        mstep_q;
	logic [PROD_W-1:0] ga_q, gb_q, g_q;
	logic [5:0]        sh_q;
	logic              pow_done_q;
	logic [6:0]        pcnt_q;
	logic [MAG_W-1:0]  basen_q, based_q;
	logic              baseneg_q;

	logic              out_valid_q;
	logic [31:0]       res_num_q;
	logic [30:0]       res_den_q;
	logic [1:0]        cmp_out_q, stat_out_q;

	logic [MAG_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic              binary_op;
	logic [3:0]        after_red;
	logic              gcd_end;
	logic [PROD_W-1:0] g_comb;
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_dividend, div_divisor, div_quot;
	logic              sub_nb;
	logic              add_neg;
	logic [PROD_W-1:0] add_mag;
	logic              ln, rn;
	logic [1:0]        cmp_code;
	logic [6:0]        pcnt_n;
	logic              fin_write;

	assign in_stall = (state_q != S_IDLE);
	assign binary_op = (op_q >= OP_ADD) && (op_q <= OP_CMP);
	assign after_red = (op_q == OP_POW && !pow_done_q) ? S_PSET : S_FIN;
	assign gcd_end = (ga_q == '0) || (gb_q == '0);
	assign g_comb = (ga_q | gb_q) << sh_q;
	assign pcnt_n = pcnt_q + 1'b1;
	assign fin_write = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		mul_a = ad_q;
		mul_b = bd_q;
		if (state_q == S_PN) begin
			mul_a = x_q[MAG_W-1:0];
			mul_b = basen_q;
		end else if (state_q == S_PD) begin
			mul_a = y_q[MAG_W-1:0];
			mul_b = based_q;
		end else if (mstep_q == 2'd0) begin
			mul_a = an_q;
			mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
		end else if (mstep_q == 2'd1) begin
			if (op_q == OP_MUL) begin
				mul_a = ad_q;
				mul_b = bd_q;
			end else if (op_q == OP_DIV) begin
				mul_a = ad_q;
				mul_b = bn_q;
			end else begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		sub_nb = (op_q == OP_SUB) ? !bneg_q : bneg_q;
		if (aneg_q == sub_nb) begin
			add_neg = aneg_q;
			add_mag = x_q + y_q;
		end else if (x_q >= y_q) begin
			add_neg = aneg_q;
			add_mag = x_q - y_q;
		end else begin
			add_neg = sub_nb;
			add_mag = y_q - x_q;
		end
		if (add_mag == '0) begin
			add_neg = 1'b0;
		end
		ln = aneg_q && (x_q != '0);
		rn = bneg_q && (y_q != '0);
		if (ln != rn) begin
			cmp_code = ln ? CMP_LT : CMP_GT;
		end else if (x_q == y_q) begin
			cmp_code = CMP_EQ;
		end else if (!ln) begin
			cmp_code = (x_q < y_q) ? CMP_LT : CMP_GT;
		end else begin
			cmp_code = (x_q > y_q) ? CMP_LT : CMP_GT;
		end
	end

	assign div_start = ((state_q == S_GCD) && gcd_end) || ((state_q == S_DIVN) && div_done);
	assign div_dividend = (state_q == S_GCD) ? x_q : y_q;
	assign div_divisor = (state_q == S_GCD) ? g_comb : g_q;

	rau_div #(.W(PROD_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_write) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DISP;
				end
				S_DISP: begin
					if (op_q > OP_POW) begin
						state_q <= S_FIN;
					end else if (ad_q == '0 || (binary_op && bd_q == '0)) begin
						state_q <= S_FIN;
					end else begin
						case (op_q) inside
							OP_ADD, OP_SUB, OP_MUL, OP_CMP: state_q <= S_MUL;
							OP_DIV: state_q <= (bn_q == '0) ? S_FIN : S_MUL;
							OP_INV: state_q <= (an_q == '0) ? S_FIN : S_RED;
							default: state_q <= S_RED;
						endcase
					end
				end
				S_MUL: begin
					if (mstep_q == 2'd2) begin
						state_q <= (op_q == OP_CMP) ? S_FIN : S_RED;
					end else if (mstep_q == 2'd1 && (op_q == OP_MUL || op_q == OP_DIV)) begin
						state_q <= S_RED;
					end
				end
				S_RED: state_q <= (x_q == '0) ? after_red : S_GCD;
				S_GCD: if (gcd_end) begin
					state_q <= S_DIVN;
				end
				S_DIVN: if (div_done) begin
					state_q <= S_DIVD;
				end
				S_DIVD: if (div_done) begin
					state_q <= after_red;
				end
				S_PSET: begin
					if (k_q == '0 || x_q == '0 || (x_q == PROD_W'(1) && y_q == PROD_W'(1))) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PN;
					end
				end
				S_PN: state_q <= S_PD;
				S_PD: begin
					if (x_q > LIM || prod > LIM) begin
						state_q <= S_FIN;
					end else if ({25'd0, pcnt_n} >= k_q || pcnt_n == 7'd64) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PN;
					end
				end
				S_FIN: if (fin_write) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= op;
			an_q <= mag(a_num);
			ad_q <= mag(a_den);
			bn_q <= mag(b_num);
			bd_q <= mag(b_den);
			aneg_q <= (a_num[31] ^ a_den[31]) && (a_num != '0);
			bneg_q <= (b_num[31] ^ b_den[31]) && (b_num != '0);
			k_q <= exponent;
		end
		unique case (state_q)
			S_IDLE: begin
			end
			S_DISP: begin
				cmp_q <= CMP_LT;
				mstep_q <= 2'd0;
				pow_done_q <= 1'b0;
				if (op_q <= OP_POW && (ad_q == '0 || (binary_op && bd_q == '0)
						|| (op_q == OP_DIV && bn_q == '0)
						|| (op_q == OP_INV && an_q == '0))) begin
					stat_q <= ST_ZERO;
				end else begin
					stat_q <= ST_OK;
				end
				if (op_q == OP_INV) begin
					x_q <= PROD_W'(ad_q);
					y_q <= PROD_W'(an_q);
				end else if (op_q == OP_RED || op_q == OP_POW || op_q == OP_NEG) begin
					x_q <= PROD_W'(an_q);
					y_q <= PROD_W'(ad_q);
				end else begin
					x_q <= '0;
					y_q <= PROD_W'(1);
				end
				if (op_q == OP_NEG) begin
					neg_q <= !aneg_q && (an_q != '0);
				end else if (op_q == OP_RED || op_q == OP_POW || op_q == OP_INV) begin
					neg_q <= aneg_q;
				end else begin
					neg_q <= 1'b0;
				end
			end
			S_MUL: begin
				mstep_q <= mstep_q + 1'b1;
				if (mstep_q == 2'd0) begin
					x_q <= prod;
				end else if (mstep_q == 2'd1) begin
					y_q <= prod;
					neg_q <= (aneg_q != bneg_q) && (x_q != '0);
				end else if (op_q == OP_CMP) begin
					cmp_q <= cmp_code;
					x_q <= '0;
					y_q <= PROD_W'(1);
					neg_q <= 1'b0;
				end else begin
					x_q <= add_mag;
					neg_q <= add_neg;
					y_q <= prod;
				end
			end
			S_RED: begin
				if (x_q == '0) begin
					y_q <= PROD_W'(1);
					neg_q <= 1'b0;
				end else begin
					ga_q <= x_q;
					gb_q <= y_q;
					sh_q <= '0;
				end
			end
			S_GCD: begin
				if (gcd_end) begin
					g_q <= g_comb;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					sh_q <= sh_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			S_DIVN: if (div_done) begin
				x_q <= div_quot;
			end
			S_DIVD: if (div_done) begin
				y_q <= div_quot;
			end
			S_PSET: begin
				pow_done_q <= 1'b1;
				basen_q <= x_q[MAG_W-1:0];
				based_q <= y_q[MAG_W-1:0];
				baseneg_q <= neg_q;
				pcnt_q <= '0;
				if (k_q == '0) begin
					x_q <= PROD_W'(1);
					y_q <= PROD_W'(1);
					neg_q <= 1'b0;
				end else if (x_q == '0) begin
					y_q <= PROD_W'(1);
					neg_q <= 1'b0;
				end else if (x_q == PROD_W'(1) && y_q == PROD_W'(1)) begin
					neg_q <= neg_q && k_q[0];
				end else begin
					x_q <= PROD_W'(1);
					y_q <= PROD_W'(1);
				end
			end
			S_PN: x_q <= prod;
			S_PD: begin
				y_q <= prod;
				pcnt_q <= pcnt_n;
				neg_q <= baseneg_q && k_q[0];
				if (x_q > LIM || prod > LIM) begin
					stat_q <= ST_OVF;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
		if (fin_write) begin
			if (stat_q != ST_OK) begin
				res_num_q <= '0;
				res_den_q <= 31'd1;
				cmp_out_q <= CMP_LT;
				stat_out_q <= stat_q;
			end else if (x_q > LIM || y_q > LIM) begin
				res_num_q <= '0;
				res_den_q <= 31'd1;
				cmp_out_q <= CMP_LT;
				stat_out_q <= ST_OVF;
			end else begin
				res_num_q <= neg_q ? (~x_q[31:0] + 1'b1) : x_q[31:0];
				res_den_q <= y_q[30:0];
				cmp_out_q <= cmp_q;
				stat_out_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign cmp_result = cmp_out_q;
	assign status = stat_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DISP) else $error("item not taken up");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_den_q != '0) else $error("zero denominator returned");
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stat_out_q != ST_OK |-> res_num_q == '0 && res_den_q == 31'd1
			&& cmp_out_q == CMP_LT) else $error("error result not cleared");
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_write |=> state_q == S_IDLE && out_valid_q) else $error("result not issued");

endmodule

// ===== rtl/rau_div.sv =====
module rau_div import rau_pkg::*; #(
	parameter int W = PROD_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dq_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    rem_sh;
	logic          fits;

	assign rem_sh = {rem_q[W-1:0], dq_q[W-1]};
	assign fits = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dq_q <= {dq_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |=> busy_q || done_q) else $error("divider lost its item");

endmodule

// ===== test/testbench.sv =====
module testbench;
	import rau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
		logic [31:0] exponent;
	} item_t;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic [1:0]  cmp;
		logic [1:0]  st;
	} answer_t;

	localparam logic [63:0] LIMIT = 64'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] op = '0;
	logic signed [31:0] a_num = '0;
	logic signed [31:0] a_den = '0;
	logic signed [31:0] b_num = '0;
	logic signed [31:0] b_den = '0;
	logic [31:0] exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic [1:0] cmp_result;
	logic [1:0] status;

	answer_t expected_answers[$];
	int error_count = 0;
	bit stall_enable = 1'b1;

	rational_arithmetic_unit i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.exponent(exponent), .out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .cmp_result(cmp_result), .status(status)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] magnitude(input logic [31:0] v);
		return v[31] ? {32'd0, -v} : {32'd0, v};
	endfunction

	function automatic logic [63:0] binary_gcd(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic answer_t compute_rational(input item_t it);
		answer_t r;
		logic an, bn, rn;
		logic [63:0] anm, adm, bnm, bdm, rnm, rdm, l, q, g;
		logic ln, qn, fail;
		logic [31:0] k;
		int i;
		r = '{num: 0, den: 1, cmp: CMP_LT, st: ST_OK};
		anm = magnitude(it.a_num);
		adm = magnitude(it.a_den);
		bnm = magnitude(it.b_num);
		bdm = magnitude(it.b_den);
		an = (it.a_num[31] != it.a_den[31]) && anm != 0;
		bn = (it.b_num[31] != it.b_den[31]) && bnm != 0;
		k = it.exponent;
		rn = 0;
		rnm = 0;
		rdm = 1;
		fail = 0;
		if (it.op > OP_POW) return r;
		if (adm == 0 || (it.op >= OP_ADD && it.op <= OP_CMP && bdm == 0)) begin
			r.st = ST_ZERO;
			return r;
		end
		case (it.op)
			OP_RED: begin
				rn = an; rnm = anm; rdm = adm;
			end
			OP_ADD, OP_SUB: begin
				l = anm * bdm;
				q = bnm * adm;
				qn = (it.op == OP_SUB) ? !bn : bn;
				if (an == qn) begin
					rn = an; rnm = l + q;
				end else if (l >= q) begin
					rn = an; rnm = l - q;
				end else begin
					rn = qn; rnm = q - l;
				end
				if (rnm == 0) rn = 0;
				rdm = adm * bdm;
			end
			OP_MUL: begin
				rnm = anm * bnm; rdm = adm * bdm; rn = (an != bn) && rnm != 0;
			end
			OP_DIV: begin
				if (bnm == 0) begin
					r.st = ST_ZERO;
					return r;
				end
				rnm = anm * bdm; rdm = adm * bnm; rn = (an != bn) && rnm != 0;
			end
			OP_CMP: begin
				l = anm * bdm;
				q = bnm * adm;
				ln = an && l != 0;
				qn = bn && q != 0;
				if (ln != qn) r.cmp = ln ? CMP_LT : CMP_GT;
				else if (l == q) r.cmp = CMP_EQ;
				else if (!ln) r.cmp = (l < q) ? CMP_LT : CMP_GT;
				else r.cmp = (l > q) ? CMP_LT : CMP_GT;
				return r;
			end
			OP_NEG: begin
				rnm = anm; rdm = adm; rn = !an && anm != 0;
			end
			OP_INV: begin
				if (anm == 0) begin
					r.st = ST_ZERO;
					return r;
				end
				rnm = adm; rdm = anm; rn = an;
			end
			default: begin
				g = binary_gcd(anm, adm);
				l = anm / g;
				q = adm / g;
				rnm = 1;
				rdm = 1;
				if (k != 0) begin
					if (l == 0) rnm = 0;
					else if (l == 1 && q == 1) rn = an && k[0];
					else begin
						for (i = 0; i < 64 && i < k; i++) begin
							rnm = rnm * l;
							rdm = rdm * q;
							if (rnm > LIMIT || rdm > LIMIT) begin
								fail = 1;
								break;
							end
						end
						rn = an && k[0];
					end
				end
			end
		endcase
		if (!fail) begin
			g = binary_gcd(rnm, rdm);
			rnm = rnm / g;
			rdm = rdm / g;
			if (rnm == 0) begin
				rn = 0; rdm = 1;
			end
			fail = rnm > LIMIT || rdm > LIMIT;
		end
		if (fail) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = rn ? -rnm[31:0] : rnm[31:0];
		r.den = rdm[30:0];
		return r;
	endfunction

	task automatic send_item(input item_t it);
		int idle;
		idle = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		a_num <= it.a_num;
		a_den <= it.a_den;
		b_num <= it.b_num;
		b_den <= it.b_den;
		exponent <= it.exponent;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_answers.push_back(compute_rational(it));
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected result %0d/%0d", res_num, res_den);
				error_count++;
			end else begin
				e = expected_answers.pop_front();
				if (res_num !== e.num) begin
					$error("res_num expected %0d actual %0d", $signed(e.num), res_num);
					error_count++;
				end
				if (res_den !== e.den) begin
					$error("res_den expected %0d actual %0d", e.den, res_den);
					error_count++;
				end
				if (cmp_result !== e.cmp) begin
					$error("cmp_result expected %0d actual %0d", e.cmp, cmp_result);
					error_count++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					error_count++;
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_enable && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 131070) - 65535;
			3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)} ^ $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t make_item(input logic [3:0] o, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd,
			input logic [31:0] k);
		item_t it;
		it.op = o; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
		it.exponent = k;
		return it;
	endfunction

	task automatic test_directed();
		send_item(make_item(OP_RED, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0));
		send_item(make_item(OP_RED, 6, -4, 0, 1, 0));
		send_item(make_item(OP_RED, 32'h8000_0000, 2, 0, 1, 0));
		send_item(make_item(OP_RED, 5, 0, 1, 1, 0));
		send_item(make_item(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 0));
		send_item(make_item(OP_ADD, 1, 3, -1, 3, 0));
		send_item(make_item(OP_ADD, 1, 2, 1, 0, 0));
		send_item(make_item(OP_SUB, 1, 2, 1, 3, 0));
		send_item(make_item(OP_SUB, 32'h8000_0000, 1, 1, 1, 0));
		send_item(make_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 3, -7, 0));
		send_item(make_item(OP_MUL, 65536, 1, 65536, 1, 0));
		send_item(make_item(OP_DIV, 3, 4, 0, 5, 0));
		send_item(make_item(OP_DIV, -3, 4, 9, -2, 0));
		send_item(make_item(OP_CMP, 1, 3, 2, 6, 0));
		send_item(make_item(OP_CMP, -1, 3, 1, 3, 0));
		send_item(make_item(OP_CMP, -2, 3, -1, 3, 0));
		send_item(make_item(OP_CMP, 1, 0, 1, 3, 0));
		send_item(make_item(OP_NEG, 0, -5, 0, 0, 0));
		send_item(make_item(OP_NEG, 32'h8000_0000, 1, 0, 0, 0));
		send_item(make_item(OP_INV, 0, 7, 0, 0, 0));
		send_item(make_item(OP_INV, -6, 4, 0, 0, 0));
		send_item(make_item(OP_POW, 0, 5, 0, 0, 0));
		send_item(make_item(OP_POW, 0, 5, 0, 0, 32'hFFFF_FFFF));
		send_item(make_item(OP_POW, -2, -2, 0, 0, 32'hFFFF_FFFF));
		send_item(make_item(OP_POW, -2, 3, 0, 0, 31));
		send_item(make_item(OP_POW, 2, 1, 0, 0, 31));
		send_item(make_item(4'hF, 1, 1, 1, 1, 1));
	endtask

	task automatic test_random();
		item_t it;
		repeat (1900) begin
			it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			it.a_num = random_value();
			it.a_den = ($urandom_range(0, 29) == 0) ? 32'd0 : random_value();
			it.b_num = random_value();
			it.b_den = ($urandom_range(0, 29) == 0) ? 32'd0 : random_value();
			it.exponent = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
			send_item(it);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		in_valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
